FILE: rtl/core/lr16k_pkg.sv
// Shared types, constants and rate helpers for the 16 kHz linear resampler.
package lr16k_pkg;

    localparam int unsigned OUT_RATE       = 16000;
    localparam int unsigned RATE_MIN       = 1000;
    localparam int unsigned RATE_MAX       = 192000;
    localparam int unsigned RATE_W         = 18;
    localparam int unsigned REM_W          = 14;
    localparam int unsigned QUOT_W         = 4;
    localparam int unsigned RATE_STEPS     = RATE_MAX / OUT_RATE;
    localparam int unsigned MAX_RESULTS    = 32;
    localparam int unsigned RES_CNT_W      = 6;
    localparam int unsigned ADDR_W         = 3;
    localparam int unsigned DATA_W         = 32;
    // 16000 = 125 << 7: shift out the power of two, then multiply by a reciprocal of 125
    localparam int unsigned DIV_SHIFT      = 7;
    localparam int unsigned DIV_ODD        = 125;
    localparam int unsigned DIV_ODD_LOG2   = 7;

    typedef enum logic [0:0] {
        REG_RATE  = 1'b0,
        REG_COUNT = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CFG_A,
        ST_CFG_B,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_TAIL,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic restart;
        logic derive;
        logic take;
        logic mul;
        logic load_num;
        logic div_step;
        logic tail;
        logic put;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic ignore;
        logic main_ok;
        logic tail_ok;
        logic out_free;
    } dp_status_t;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] r;
        r = rate;
        if (r < RATE_W'(RATE_MIN)) r = RATE_W'(RATE_MIN);
        if (r > RATE_W'(RATE_MAX)) r = RATE_W'(RATE_MAX);
        return r;
    endfunction

    // whole samples per output step: count of output-rate multiples at or below the rate
    function automatic logic [QUOT_W-1:0] rate_quot(input logic [RATE_W-1:0] rate);
        logic [QUOT_W-1:0] q;
        q = '0;
        for (int k = 1; k <= int'(RATE_STEPS); k++)
        begin
            if (rate >= RATE_W'(k * int'(OUT_RATE))) q = q + QUOT_W'(1);
        end
        return q;
    endfunction

    function automatic logic [REM_W-1:0] rate_rem(input logic [RATE_W-1:0] rate,
                                                  input logic [QUOT_W-1:0] q);
        logic [RATE_W-1:0] t;
        t = rate - RATE_W'(q * RATE_W'(OUT_RATE));
        return t[REM_W-1:0];
    endfunction

endpackage

FILE: rtl/core/linear_resampler_to_16k_top.sv
// Top level of the linear-interpolation resampler to 16 kHz.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_stall    | sample_in
//  output   | out_valid / out_stall  | sample_out, last_of_run, end_of_stream
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (0: rate, 4: count)
//
//  An input beat is taken in idle; each interpolated result then passes multiply, sum,
//  reciprocal divide by 16000 and output load, each tail repeat load and output load.
//  A register write stalls the input during its access and the restart and derive states.
//  A stalled output holds the datapath only when a further result needs the output
//  register; the last result of a beat can wait while the next input is taken.
//  Reset is asynchronous; no clearing pass is needed.
module linear_resampler_to_16k_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lr16k_pkg::ADDR_W-1:0]    paddr,
    input  logic [lr16k_pkg::DATA_W-1:0]    pwdata,
    output logic [lr16k_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_BITS-1:0]   sample_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]   sample_out,
    output logic                            last_of_run,
    output logic                            end_of_stream
);

    logic [lr16k_pkg::RATE_W-1:0]   source_rate;
    logic [COUNT_BITS-1:0]          sample_count;
    logic                           cfg_wr;
    lr16k_pkg::dp_cmd_t             cmd;
    lr16k_pkg::dp_status_t          status;

    lr16k_regs #(
        .COUNT_BITS   (COUNT_BITS)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .source_rate  (source_rate),
        .sample_count (sample_count),
        .cfg_wr       (cfg_wr)
    );

    lr16k_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lr16k_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .source_rate   (source_rate),
        .sample_count  (sample_count),
        .sample_in     (sample_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

endmodule

FILE: rtl/core/lr16k_regs.sv
// APB register file: source rate and sample count.
module lr16k_regs #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lr16k_pkg::ADDR_W-1:0]        paddr,
    input  logic [lr16k_pkg::DATA_W-1:0]        pwdata,
    output logic [lr16k_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [lr16k_pkg::RATE_W-1:0]        source_rate,
    output logic [COUNT_BITS-1:0]               sample_count,
    output logic                                cfg_wr
);

    logic [lr16k_pkg::RATE_W-1:0] rate_reg;
    logic [lr16k_pkg::RATE_W-1:0] rate_next;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;
    lr16k_pkg::reg_sel_t          sel;

    assign pready = 1'b1;
    assign sel    = lr16k_pkg::reg_sel_t'(paddr[2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        rate_next  = rate_reg;
        count_next = count_reg;
        if (cfg_wr)
        begin
            unique case (sel)
                lr16k_pkg::REG_RATE:  rate_next  = pwdata[lr16k_pkg::RATE_W-1:0];
                lr16k_pkg::REG_COUNT: count_next = pwdata[COUNT_BITS-1:0];
                default:              rate_next  = rate_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            lr16k_pkg::REG_RATE:  prdata = lr16k_pkg::DATA_W'(rate_reg);
            lr16k_pkg::REG_COUNT: prdata = lr16k_pkg::DATA_W'(count_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= lr16k_pkg::RATE_W'(lr16k_pkg::OUT_RATE);
            count_reg <= '0;
        end
        else
        begin
            rate_reg  <= rate_next;
            count_reg <= count_next;
        end
    end

    assign source_rate  = rate_reg;
    assign sample_count = count_reg;

endmodule

FILE: rtl/core/lr16k_ctrl.sv
// Sequencer: walks each input through its output steps and drives the datapath.
module lr16k_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  lr16k_pkg::dp_status_t   status,
    output lr16k_pkg::dp_cmd_t      cmd
);

    lr16k_pkg::state_t      state_reg;
    lr16k_pkg::state_t      state_next;
    logic                   more;

    assign more     = status.main_ok || status.tail_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = lr16k_pkg::ST_CFG_A;
        end
        else
        begin
            unique case (state_reg)
                lr16k_pkg::ST_IDLE:
                begin
                    if (in_valid && !status.ignore)
                    begin
                        if (status.main_ok)      state_next = lr16k_pkg::ST_MUL;
                        else if (status.tail_ok) state_next = lr16k_pkg::ST_TAIL;
                    end
                end
                lr16k_pkg::ST_CFG_A: state_next = lr16k_pkg::ST_CFG_B;
                lr16k_pkg::ST_CFG_B: state_next = lr16k_pkg::ST_IDLE;
                lr16k_pkg::ST_MUL:   state_next = lr16k_pkg::ST_ADD;
                lr16k_pkg::ST_ADD:   state_next = lr16k_pkg::ST_DIV;
                lr16k_pkg::ST_DIV:   state_next = lr16k_pkg::ST_PUT;
                lr16k_pkg::ST_TAIL:  state_next = lr16k_pkg::ST_PUT;
                lr16k_pkg::ST_PUT:
                begin
                    if (status.out_free)
                    begin
                        if (status.main_ok)      state_next = lr16k_pkg::ST_MUL;
                        else if (status.tail_ok) state_next = lr16k_pkg::ST_TAIL;
                        else                     state_next = lr16k_pkg::ST_IDLE;
                    end
                end
                default: state_next = lr16k_pkg::ST_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            lr16k_pkg::ST_IDLE:
            begin
                in_stall = cfg_wr;
                if (in_valid && !cfg_wr && !status.ignore)
                begin
                    cmd.take   = 1'b1;
                    cmd.finish = !more;
                end
            end
            lr16k_pkg::ST_CFG_A: cmd.restart  = 1'b1;
            lr16k_pkg::ST_CFG_B: cmd.derive   = 1'b1;
            lr16k_pkg::ST_MUL:   cmd.mul      = 1'b1;
            lr16k_pkg::ST_ADD:   cmd.load_num = 1'b1;
            lr16k_pkg::ST_DIV:   cmd.div_step = 1'b1;
            lr16k_pkg::ST_TAIL:  cmd.tail     = 1'b1;
            lr16k_pkg::ST_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put    = 1'b1;
                    cmd.finish = !more;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lr16k_pkg::ST_IDLE;
        end
        else
        begin
            state_reg   <= state_next;
        end
    end

endmodule

FILE: rtl/core/lr16k_dp.sv
// Datapath: position tracking, interpolation multiply, divide by 16000, output register.
module lr16k_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lr16k_pkg::dp_cmd_t                  cmd,
    output lr16k_pkg::dp_status_t               status,
    input  logic [lr16k_pkg::RATE_W-1:0]        source_rate,
    input  logic [COUNT_BITS-1:0]               sample_count,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                last_of_run,
    output logic                                end_of_stream
);

    localparam int REM_W      = int'(lr16k_pkg::REM_W);
    localparam int NUM_W      = SAMPLE_BITS + REM_W;
    localparam int PROD_W     = SAMPLE_BITS + 16;
    localparam int ACC_W      = COUNT_BITS + 16;
    localparam int BOUND_W    = COUNT_BITS + REM_W;
    localparam int RATE_W     = int'(lr16k_pkg::RATE_W);
    localparam int QUOT_W     = int'(lr16k_pkg::QUOT_W);
    localparam int RES_CNT_W  = int'(lr16k_pkg::RES_CNT_W);
    localparam int DIV_SH     = int'(lr16k_pkg::DIV_SHIFT);
    localparam int DVD_W      = NUM_W - DIV_SH;
    localparam int RECIP_SH   = DVD_W + int'(lr16k_pkg::DIV_ODD_LOG2);
    localparam int RECIP_W    = DVD_W + 1;
    localparam int QPROD_W    = DVD_W + RECIP_W;
    // ceil(2^RECIP_SH / 125): exact floor division for every DVD_W-bit dividend
    localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH)
                                          + 64'(lr16k_pkg::DIV_ODD) - 64'd1)
                                         / 64'(lr16k_pkg::DIV_ODD);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // rate and stream setup
    logic [RATE_W-1:0]              eff_reg,   eff_next;
    logic [QUOT_W-1:0]              quot_reg,  quot_next;
    logic [REM_W-1:0]               rrem_reg,  rrem_next;
    logic [BOUND_W-1:0]             bound_reg, bound_next;
    // stream position
    logic signed [SAMPLE_BITS-1:0]  prev_reg,  prev_next;
    logic [COUNT_BITS-1:0]          idx_reg,   idx_next;
    logic [COUNT_BITS-1:0]          pw_reg,    pw_next;
    logic [REM_W-1:0]               pr_reg,    pr_next;
    logic [ACC_W-1:0]               acc_reg,   acc_next;
    logic [RES_CNT_W-1:0]           n_reg,     n_next;
    // arithmetic pipeline
    logic signed [SAMPLE_BITS-1:0]  x_reg,     x_next;
    logic signed [PROD_W-1:0]       prod_reg,  prod_next;
    logic [NUM_W-1:0]               num_reg,   num_next;
    logic [SAMPLE_BITS-1:0]         qr_reg,    qr_next;
    logic                           eosp_reg,  eosp_next;
    // output beat
    logic                           ov_reg,    ov_next;
    logic signed [SAMPLE_BITS-1:0]  so_reg,    so_next;
    logic                           last_reg,  last_next;
    logic                           eos_reg,   eos_next;

    logic                           acc_le;
    logic                           more;
    logic [RATE_W-1:0]              eff_w;
    logic [QUOT_W-1:0]              quot_w;
    logic [REM_W:0]                 pr_sum;
    logic                           pr_wrap;
    logic signed [SAMPLE_BITS:0]    diff;
    logic signed [REM_W:0]          frac_s;
    logic [NUM_W-1:0]               num_sum;
    logic [SAMPLE_BITS-1:0]         a_bias;
    logic [QPROD_W-1:0]             qprod;

    assign acc_le = (acc_reg <= ACC_W'(bound_reg));

    assign status.ignore   = (idx_reg >= sample_count);
    assign status.main_ok  = (idx_reg != '0) && acc_le
                             && (pw_reg == idx_reg - COUNT_BITS'(1))
                             && (n_reg != RES_CNT_W'(lr16k_pkg::MAX_RESULTS));
    assign status.tail_ok  = ((COUNT_BITS+1)'(idx_reg) + (COUNT_BITS+1)'(1)
                              == (COUNT_BITS+1)'(sample_count))
                             && acc_le
                             && (n_reg != RES_CNT_W'(lr16k_pkg::MAX_RESULTS));
    assign status.out_free = !ov_reg || !out_stall;
    assign more            = status.main_ok || status.tail_ok;

    assign eff_w   = lr16k_pkg::clamp_rate(source_rate);
    assign quot_w  = lr16k_pkg::rate_quot(eff_reg);

    assign pr_sum  = {1'b0, pr_reg} + {1'b0, rrem_reg};
    assign pr_wrap = (pr_sum >= (REM_W+1)'(lr16k_pkg::OUT_RATE));

    assign diff    = (SAMPLE_BITS+1)'(x_reg) - (SAMPLE_BITS+1)'(prev_reg);
    assign frac_s  = $signed({1'b0, pr_reg});
    assign a_bias  = prev_reg ^ SIGN_BIT;
    // a*16000 + (b-a)*rem + 8000, nonnegative and below 2^(SAMPLE_BITS+14)
    assign num_sum = NUM_W'(a_bias) * NUM_W'(lr16k_pkg::OUT_RATE)
                     + NUM_W'(prod_reg)
                     + NUM_W'(lr16k_pkg::OUT_RATE / 2);

    // divide by 16000: drop the factor 128, then reciprocal multiply for 125
    assign qprod   = QPROD_W'(num_reg[NUM_W-1:DIV_SH]) * QPROD_W'(RECIP);

    always_comb
    begin
        eff_next   = eff_reg;
        quot_next  = quot_reg;
        rrem_next  = rrem_reg;
        bound_next = bound_reg;
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        pw_next    = pw_reg;
        pr_next    = pr_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        qr_next    = qr_reg;
        eosp_next  = eosp_reg;
        ov_next    = ov_reg && out_stall;
        so_next    = so_reg;
        last_next  = last_reg;
        eos_next   = eos_reg;

        if (cmd.restart)
        begin
            eff_next   = eff_w;
            bound_next = BOUND_W'(sample_count) * BOUND_W'(lr16k_pkg::OUT_RATE);
            prev_next  = '0;
            idx_next   = '0;
            pw_next    = '0;
            pr_next    = '0;
            acc_next   = ACC_W'(eff_w);
            n_next     = '0;
        end

        if (cmd.derive)
        begin
            quot_next = quot_w;
            rrem_next = lr16k_pkg::rate_rem(eff_reg, quot_w);
        end

        if (cmd.take)
            x_next = sample_in;

        if (cmd.mul)
            prod_next = diff * frac_s;

        // both output kinds step the position and note end of stream
        if (cmd.mul || cmd.tail)
        begin
            eosp_next = (acc_reg + ACC_W'(eff_reg)) > ACC_W'(bound_reg);
            pr_next   = pr_wrap ? REM_W'(pr_sum - (REM_W+1)'(lr16k_pkg::OUT_RATE))
                                : pr_sum[REM_W-1:0];
            pw_next   = pw_reg + COUNT_BITS'(quot_reg) + COUNT_BITS'(pr_wrap);
            acc_next  = acc_reg + ACC_W'(eff_reg);
            n_next    = n_reg + RES_CNT_W'(1);
        end

        if (cmd.tail)
            qr_next = x_reg ^ SIGN_BIT;

        if (cmd.load_num)
            num_next = num_sum;

        if (cmd.div_step)
            qr_next = qprod[RECIP_SH +: SAMPLE_BITS];

        if (cmd.put)
        begin
            ov_next   = 1'b1;
            so_next   = $signed(qr_reg ^ SIGN_BIT);
            last_next = !more;
            eos_next  = eosp_reg;
        end

        if (cmd.finish)
        begin
            prev_next = cmd.take ? sample_in : x_reg;
            idx_next  = idx_reg + COUNT_BITS'(1);
            n_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg   <= RATE_W'(lr16k_pkg::OUT_RATE);
            quot_reg  <= QUOT_W'(1);
            rrem_reg  <= '0;
            bound_reg <= '0;
            prev_reg  <= '0;
            idx_reg   <= '0;
            pw_reg    <= '0;
            pr_reg    <= '0;
            acc_reg   <= ACC_W'(lr16k_pkg::OUT_RATE);
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            eff_reg   <= eff_next;
            quot_reg  <= quot_next;
            rrem_reg  <= rrem_next;
            bound_reg <= bound_next;
            prev_reg  <= prev_next;
            idx_reg   <= idx_next;
            pw_reg    <= pw_next;
            pr_reg    <= pr_next;
            acc_reg   <= acc_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        qr_reg   <= qr_next;
        eosp_reg <= eosp_next;
        so_reg   <= so_next;
        last_reg <= last_next;
        eos_reg  <= eos_next;
    end

    assign out_valid     = ov_reg;
    assign sample_out    = so_reg;
    assign last_of_run   = last_reg;
    assign end_of_stream = eos_reg;

endmodule

FILE: rtl/core/lr16k_checker.sv
// Port-level checks for the resampler top, bound to it.
module lr16k_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [SAMPLE_BITS-1:0]    sample_out,
    input logic                             last_of_run,
    input logic                             end_of_stream
);

    // a register write rederives the rate before the next input beat
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> in_stall)
        else $error("input not stalled after register write");

    // the stream's final sample is always the last result of its input beat
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_stream) |-> last_of_run)
        else $error("end_of_stream without last_of_run");

    // nothing follows the end of the stream until the next register write
    a_eos_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && end_of_stream) |=> !out_valid)
        else $error("output beat after end of stream");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_out)
            && $stable(last_of_run) && $stable(end_of_stream)))
        else $error("stalled output beat changed");

endmodule

bind linear_resampler_to_16k_top lr16k_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lr16k_checker (.*);

FILE: bench/lr16k_tb_pkg.sv
// Output predictor and scoreboard class for the 16 kHz resampler bench.
`timescale 1ns / 1ps
package lr16k_tb_pkg;
    import lr16k_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               eos;
    } out_beat_t;

    class resample_scoreboard;
        logic [RATE_W-1:0] rate_reg;
        logic [23:0]       count_reg;
        int                prev_sample;
        longint unsigned   in_index;
        longint unsigned   pos_whole;
        longint unsigned   pos_rem;
        longint unsigned   bound_acc;
        out_beat_t         due_q[$];
        int                errors;
        int                outs_seen;

        function new();
            rate_reg  = RATE_W'(OUT_RATE);
            count_reg = '0;
            errors    = 0;
            outs_seen = 0;
            restart();
        endfunction

        function longint unsigned used_rate();
            longint unsigned r;
            r = rate_reg;
            if (r < RATE_MIN) r = RATE_MIN;
            if (r > RATE_MAX) r = RATE_MAX;
            return r;
        endfunction

        function void restart();
            prev_sample = 0;
            in_index    = 0;
            pos_whole   = 0;
            pos_rem     = 0;
            bound_acc   = used_rate();
        endfunction

        // any register write opens a new stream
        function void write_reg(reg_sel_t sel, logic [31:0] value);
            if (sel == REG_RATE)
                rate_reg = value[RATE_W-1:0];
            else
                count_reg = value[23:0];
            restart();
        endfunction

        // exact a*(16000-r) + b*r over 16000, rounded half up, on offset-binary values
        function int blend(int a, int b, longint unsigned r);
            longint unsigned ua, ub, num;
            ua  = a + 32768;
            ub  = b + 32768;
            num = ua * (OUT_RATE - r) + ub * r + OUT_RATE / 2;
            return int'(num / OUT_RATE) - 32768;
        endfunction

        function void step_position(longint unsigned rate);
            pos_rem   += rate % OUT_RATE;
            pos_whole += rate / OUT_RATE;
            if (pos_rem >= OUT_RATE)
            begin
                pos_rem   -= OUT_RATE;
                pos_whole += 1;
            end
            bound_acc += rate;
        endfunction

        function void note_input(logic signed [15:0] x);
            longint unsigned rate, limit, k;
            out_beat_t       run[$];
            out_beat_t       b;
            rate  = used_rate();
            limit = count_reg;
            limit = limit * OUT_RATE;
            k     = in_index;
            if (k >= count_reg) return;
            if (k >= 1)
            begin
                while (run.size() < MAX_RESULTS && bound_acc <= limit && pos_whole == k - 1)
                begin
                    b.sample = 16'(blend(prev_sample, int'(x), pos_rem));
                    b.last   = 1'b0;
                    b.eos    = (bound_acc + rate > limit);
                    run.insert(run.size(), b);
                    step_position(rate);
                end
            end
            // final sample: positions past the last pair repeat it
            if (k + 1 == count_reg)
            begin
                while (run.size() < MAX_RESULTS && bound_acc <= limit)
                begin
                    b.sample = x;
                    b.last   = 1'b0;
                    b.eos    = (bound_acc + rate > limit);
                    run.insert(run.size(), b);
                    step_position(rate);
                end
            end
            if (run.size() > 0)
            begin
                b = run[run.size() - 1];
                b.last = 1'b1;
                run[run.size() - 1] = b;
            end
            foreach (run[i]) due_q.insert(due_q.size(), run[i]);
            prev_sample = x;
            in_index    = (k + 1) & 64'hFF_FFFF;
        endfunction

        function void check_output(logic signed [15:0] sample, logic last, logic eos);
            out_beat_t want;
            outs_seen++;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("output %0d: unexpected beat, sample %0d last %0b eos %0b",
                             outs_seen, sample, last, eos);
                return;
            end
            want = due_q.pop_front();
            if (sample !== want.sample || last !== want.last || eos !== want.eos)
            begin
                errors++;
                if (errors <= 10)
                    $display("output %0d: expected sample %0d last %0b eos %0b, got %0d %0b %0b",
                             outs_seen, want.sample, want.last, want.eos, sample, last, eos);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

endpackage

FILE: bench/tb_linear_resampler_to_16k_top.sv
// Bench top for the 16 kHz resampler: clock, reset, drivers and run control.
`timescale 1ns / 1ps
module tb_linear_resampler_to_16k_top;
    import lr16k_pkg::*;
    import lr16k_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 480;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [15:0]     sample_in;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [15:0]     sample_out;
    logic                   last_of_run;
    logic                   end_of_stream;

    resample_scoreboard sb;
    int       cycles      = 0;
    int       stall_phase = 0;
    rx_mode_t stall_mode  = RX_FREE;
    int       burst_left;
    int       max_gap;
    int       taken_items;

    linear_resampler_to_16k_top u_top (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** linear_resampler_to_16k_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_output(sample_out, last_of_run, end_of_stream);

    // receiver stall pattern: random modes held for random stretches
    always @(negedge clk) begin
        if (stall_phase == 0) begin
            stall_mode  = rx_mode_t'($urandom_range(0, 3));
            stall_phase = $urandom_range(16, 160);
        end
        stall_phase--;
        case (stall_mode)
            RX_FREE:     out_stall = 1'b0;
            RX_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
            RX_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
            default:     out_stall = ((cycles % 7) < 3);
        endcase
    end

    task automatic apb_write(input reg_sel_t sel, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(sel, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [31:0] rate, input logic [31:0] count);
        apb_write(REG_RATE, rate);
        apb_write(REG_COUNT, count);
    endtask

    // one input beat; the sender runs in bursts with random gaps between them
    task automatic send_sample(input logic signed [15:0] v);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, max_gap)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid  = 1'b1;
        sample_in = v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(v);
        @(negedge clk);
    endtask

    // beats with no result can still be in flight, so hold off after the queue drains
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_stream();
        logic [31:0]        rate;
        logic [31:0]        rate_word;
        logic signed [15:0] v;
        int                 n;
        int                 total;
        int                 wave;
        int                 level;
        case ($urandom_range(0, 9))
            0:       rate = 8000;
            1:       rate = 11025;
            2:       rate = 22050;
            3:       rate = 44100;
            4:       rate = 48000;
            5:       rate = $urandom_range(0, RATE_MIN - 1);
            6:       rate = $urandom_range(RATE_MAX + 1, 262143);
            7:       rate = OUT_RATE;
            default: rate = $urandom_range(RATE_MIN, RATE_MAX);
        endcase
        // junk above the register width must not matter
        rate_word = rate;
        if ($urandom_range(0, 3) == 0) rate_word[31:RATE_W] = $urandom;
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
        case ($urandom_range(0, 3))
            0: begin
                apb_write(REG_COUNT, n);
                apb_write(REG_RATE, rate_word);
            end
            1: begin
                if (sb.count_reg <= 40)
                    apb_write(REG_RATE, rate_word);
                else
                    configure(rate_word, n);
            end
            default: configure(rate_word, n);
        endcase
        n     = int'(sb.count_reg);
        total = n + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        max_gap    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = 0;
        wave  = $urandom_range(0, 3);
        level = 0;
        for (int i = 0; i < total; i++) begin
            case (wave)
                2: v = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                3: begin
                    level += int'($urandom_range(0, 4000)) - 2000;
                    if (level > 32767) level = 32767;
                    if (level < -32768) level = -32768;
                    v = 16'(level);
                end
                default: v = 16'($urandom);
            endcase
            send_sample(v);
        end
        taken_items += n;
        settle();
    endtask

    initial begin
        sb          = new();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        sample_in   = '0;
        out_stall   = 1'b0;
        burst_left  = 0;
        max_gap     = 0;
        taken_items = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // count is zero out of reset: every beat is dropped
        send_sample(16'sd100);
        send_sample(-16'sd100);
        settle();

        // pass-through at 16 kHz, last beat lies past the count
        configure(OUT_RATE, 6);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd12345);
        send_sample(16'sd777);
        settle();

        // slowest rate: 16 results per beat, full result cap on the final beat
        max_gap = 3;
        configure(RATE_MIN, 3);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        settle();

        // rate below the floor saturates; single sample gives tail repeats only
        configure(500, 1);
        send_sample(16'sd4242);
        settle();

        // all-ones rate saturates at the ceiling
        configure(32'h3_FFFF, 12);
        for (int i = 0; i < 12; i++) send_sample(16'($urandom));
        settle();

        // largest count; stream is left unfinished
        configure(44100, 32'hFF_FFFF);
        send_sample(-16'sd20000);
        send_sample(16'sd31000);
        send_sample(-16'sd5);
        settle();

        while (taken_items < RANDOM_ITEMS) random_stream();
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** linear_resampler_to_16k_top: PASSED **");
        else
            $display("** linear_resampler_to_16k_top: FAILED **");
        $finish;
    end

endmodule
